### rtl/core/sio_cfg_pkg.sv
// Shared types, constants and the serial base decode function of the super I/O configuration port.
`default_nettype none

package sio_cfg_pkg;

	localparam int unsigned NumRegs = 16;
	localparam int unsigned IdxW    = $clog2(NumRegs);

	// Access codes.
	localparam logic OP_READ    = 1'b0;
	localparam logic OP_WRITE   = 1'b1;
	localparam logic PORT_INDEX = 1'b0;
	localparam logic PORT_DATA  = 1'b1;

	// Unlock and lock keys written to the index port.
	localparam logic [7:0] KEY_ENTER = 8'h55;
	localparam logic [7:0] KEY_EXIT  = 8'hAA;

	// Register numbers used by the resource decode.
	localparam logic [IdxW-1:0] REG_FDC  = IdxW'(0);
	localparam logic [IdxW-1:0] REG_PAR  = IdxW'(1);
	localparam logic [IdxW-1:0] REG_SER  = IdxW'(2);
	localparam logic [IdxW-1:0] REG_FMOD = IdxW'(3);
	localparam logic [IdxW-1:0] REG_FOPT = IdxW'(5);

	localparam logic [7:0] REG_RESET [NumRegs] = '{
		8'h3A, 8'h9F, 8'hDC, 8'h78, 8'h00, 8'h00, 8'hFF, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h65, 8'h01, 8'h00
	};

	// Base addresses.
	localparam logic [9:0] BASE_NONE    = 10'h000;
	localparam logic [9:0] FDC_PRIMARY  = 10'h3F0;
	localparam logic [9:0] FDC_SECOND   = 10'h370;
	localparam logic [9:0] PAR_MONO     = 10'h3BC;
	localparam logic [9:0] PAR_FIRST    = 10'h378;
	localparam logic [9:0] PAR_SECOND   = 10'h278;
	localparam logic [9:0] SER_FIRST    = 10'h3F8;
	localparam logic [9:0] SER_SECOND   = 10'h2F8;

	localparam logic [9:0] SER_THIRD  [4] = '{10'h338, 10'h3E8, 10'h2E8, 10'h220};
	localparam logic [9:0] SER_FOURTH [4] = '{10'h238, 10'h2E8, 10'h2E0, 10'h228};

	typedef enum logic [2:0] {
		ST_LOCKED = 3'b001,
		ST_KEY    = 3'b010,
		ST_OPEN   = 3'b100
	} lock_state_t;

	// One bus access as captured in the input register.
	typedef struct packed {
		logic       valid;
		logic       opcode;
		logic       port_select;
		logic [7:0] data;
	} access_t;

	// Result of one access and the register contents after it.
	typedef struct packed {
		logic       config_mode;
		logic       pass;
		logic [7:0] read_data;
		logic [7:0] r_fdc;
		logic [7:0] r_par;
		logic [7:0] r_ser;
		logic [7:0] r_fmod;
		logic [7:0] r_fopt;
	} view_t;

	// Decoded resource assignment.
	typedef struct packed {
		logic [9:0] floppy_base;
		logic [9:0] parallel_base;
		logic [9:0] serial_one_base;
		logic [9:0] serial_two_base;
		logic       os2_mode;
		logic [1:0] density_force;
		logic       drive_swap;
	} resources_t;

	function automatic logic [9:0] serial_base(input logic en, input logic [1:0] sel,
		input logic [1:0] alt);
		logic [9:0] b;
		case (sel)
			2'd0:    b = SER_FIRST;
			2'd1:    b = SER_SECOND;
			2'd2:    b = SER_THIRD[alt];
			default: b = SER_FOURTH[alt];
		endcase
		return en ? b : BASE_NONE;
	endfunction

endpackage

`default_nettype wire

### rtl/core/sio_cfg_regs.sv
// Lock sequencer, index register and register file of the configuration port.
`default_nettype none

module sio_cfg_regs (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire sio_cfg_pkg::access_t  acc,
	output sio_cfg_pkg::view_t         view
);
	import sio_cfg_pkg::*;

	lock_state_t      state_q, state_d;
	logic [IdxW-1:0]  index_q, index_d;
	logic [7:0]       regs_q [NumRegs];
	logic [7:0]       regs_d [NumRegs];
	logic             idx_wr, data_wr, unlocked;

	assign unlocked = (state_q == ST_OPEN);
	assign idx_wr   = acc.valid && (acc.opcode == OP_WRITE) && (acc.port_select == PORT_INDEX);
	assign data_wr  = acc.valid && (acc.opcode == OP_WRITE) && (acc.port_select == PORT_DATA)
		&& unlocked;

	always_comb begin
		state_d = state_q;
		index_d = index_q;
		if (idx_wr) begin
			unique case (state_q)
				ST_LOCKED: state_d = (acc.data == KEY_ENTER) ? ST_KEY : ST_LOCKED;
				ST_KEY:    state_d = (acc.data == KEY_ENTER) ? ST_OPEN : ST_LOCKED;
				ST_OPEN: begin
					if (acc.data[7:IdxW] == '0)
						index_d = acc.data[IdxW-1:0];
					if (acc.data == KEY_EXIT)
						state_d = ST_LOCKED;
				end
				default:   state_d = ST_LOCKED;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < NumRegs; i++) begin
			regs_d[i] = (data_wr && index_q == IdxW'(i)) ? acc.data : regs_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOCKED;
			index_q <= '0;
			for (int i = 0; i < NumRegs; i++)
				regs_q[i] <= REG_RESET[i];
		end else begin
			state_q <= state_d;
			index_q <= index_d;
			for (int i = 0; i < NumRegs; i++)
				regs_q[i] <= regs_d[i];
		end
	end

	// Reads never change state, so they see the current contents.
	always_comb begin
		view.read_data = '0;
		view.pass      = 1'b0;
		if (acc.opcode == OP_READ) begin
			if (!unlocked)
				view.pass = 1'b1;
			else if (acc.port_select == PORT_INDEX)
				view.read_data = {{(8-IdxW){1'b0}}, index_q};
			else
				view.read_data = regs_q[index_q];
		end
		view.config_mode = (state_d == ST_OPEN);
		view.r_fdc       = regs_d[REG_FDC];
		view.r_par       = regs_d[REG_PAR];
		view.r_ser       = regs_d[REG_SER];
		view.r_fmod      = regs_d[REG_FMOD];
		view.r_fopt      = regs_d[REG_FOPT];
	end

endmodule

`default_nettype wire

### rtl/core/sio_cfg_decode.sv
// Resource address decode from the configuration registers.
`default_nettype none

module sio_cfg_decode (
	input  wire sio_cfg_pkg::view_t  view,
	output sio_cfg_pkg::resources_t  res
);
	import sio_cfg_pkg::*;

	always_comb begin
		if (view.r_fdc[4:3] == 2'b11)
			res.floppy_base = view.r_fopt[0] ? FDC_SECOND : FDC_PRIMARY;
		else
			res.floppy_base = BASE_NONE;

		case (view.r_par[1:0])
			2'd1:    res.parallel_base = PAR_MONO;
			2'd2:    res.parallel_base = PAR_FIRST;
			2'd3:    res.parallel_base = PAR_SECOND;
			default: res.parallel_base = BASE_NONE;
		endcase

		res.serial_one_base = serial_base(view.r_ser[2], view.r_ser[1:0], view.r_par[6:5]);
		res.serial_two_base = serial_base(view.r_ser[6], view.r_ser[5:4], view.r_par[6:5]);
		res.os2_mode        = view.r_fmod[1];
		res.density_force   = view.r_fopt[4:3];
		res.drive_swap      = view.r_fopt[5];
	end

endmodule

`default_nettype wire

### rtl/core/super_io_config_port.sv
// Top level of the super I/O configuration port: input register, state and result register.
`default_nettype none

// Usage.
// Each word on the input side is one bus access: opcode selects read or write, port_select
// picks the index port or the data port, and write_data carries the byte of a write.
// A word is taken at a rising edge where start is high and busy is low. busy is always
// low, so a new access may be presented in every cycle and one word per cycle goes through.
// The access is captured in an input register, applied to the lock sequencer, index
// register and sixteen-entry register file in the following cycle, and its result is
// registered at the end of that cycle. The result word therefore sits on the ports from
// the result register, with done high for the cycle in which it is shown, and is taken at
// the rising edge that ends that cycle. The receiver cannot stall it, so a result not taken
// in that cycle is lost. Accesses are applied strictly in order.
// Every result carries the read byte (or the pass-through flag for a read while locked),
// the configuration-mode flag after the access, and the resource assignment decoded from
// the register file after the access.
// Reset is asynchronous and active low: the port comes up locked with index zero, the
// register file at its default contents, and no access or result in flight.

module super_io_config_port (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	output logic       busy,
	input  wire        opcode,
	input  wire        port_select,
	input  wire  [7:0] write_data,
	output logic       done,
	output logic [7:0] read_data,
	output logic       pass_to_floppy,
	output logic       config_mode,
	output logic [9:0] floppy_base,
	output logic [9:0] parallel_base,
	output logic [9:0] serial_one_base,
	output logic [9:0] serial_two_base,
	output logic       os2_mode,
	output logic [1:0] density_force,
	output logic       drive_swap
);
	import sio_cfg_pkg::*;

	access_t    acc_s1;
	view_t      view;
	resources_t res;
	logic       done_s2;

	// State update and decode are combinational, so the port never holds off a word.
	assign busy = 1'b0;

	// Input register. Only the valid flag matters after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1 <= '0;
		end else begin
			acc_s1.valid       <= start && !busy;
			acc_s1.opcode      <= opcode;
			acc_s1.port_select <= port_select;
			acc_s1.data        <= write_data;
		end
	end

	sio_cfg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc_s1),
		.view   (view)
	);

	sio_cfg_decode u_decode (
		.view (view),
		.res  (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_s2 <= 1'b0;
		else
			done_s2 <= acc_s1.valid;
	end

	always_ff @(posedge clk) begin
		if (acc_s1.valid) begin
			read_data       <= view.read_data;
			pass_to_floppy  <= view.pass;
			config_mode     <= view.config_mode;
			floppy_base     <= res.floppy_base;
			parallel_base   <= res.parallel_base;
			serial_one_base <= res.serial_one_base;
			serial_two_base <= res.serial_two_base;
			os2_mode        <= res.os2_mode;
			density_force   <= res.density_force;
			drive_swap      <= res.drive_swap;
		end
	end

	assign done = done_s2;

`ifndef NO_ASSERTIONS
	// Every accepted word yields its result strobe after passing the input and result registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("result strobe missing two cycles after an accepted word");

	// A result is only produced for a word that was accepted.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result strobe without an accepted word");

	// A pass-through read only happens while the port is locked.
	a_pass_locked: assert property (@(posedge clk) disable iff (!arst_n)
		done && pass_to_floppy |-> !config_mode && read_data == 8'h00)
		else $error("pass-through flagged while unlocked or with read data");

	// The floppy controller base is one of its two addresses or disabled.
	a_fdc_base: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> floppy_base == BASE_NONE || floppy_base == FDC_PRIMARY
			|| floppy_base == FDC_SECOND)
		else $error("floppy base address outside its legal set");
`endif

endmodule

`default_nettype wire
